FILE: design/pfpv_pkg.sv
// Package for the parallel flash program/verify sequencer.
// Holds the item codes, the job descriptor passed from front to back, and bus constants.
// No dependencies.
package pfpv_pkg;

   // Fixed widths of the item fields.
   localparam int ADDR_W = 19;
   localparam int SIZE_W = 20;
   localparam int BYTE_W = 8;
   // Byte position reaches the size rounded up to a whole chunk (chunk at most 64 KiB).
   localparam int POS_W = 21;

   // Largest image the flash holds.
   localparam logic [31:0] FLASH_BYTES = 32'd524288;

   // Job queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // Unlock sequence written ahead of each page.
   localparam logic [ADDR_W-1:0] UNLOCK_ADDR_1 = 19'h05555;
   localparam logic [ADDR_W-1:0] UNLOCK_ADDR_2 = 19'h02AAA;
   localparam logic [ADDR_W-1:0] UNLOCK_ADDR_3 = 19'h05555;
   localparam logic [BYTE_W-1:0] UNLOCK_DATA_1 = 8'hAA;
   localparam logic [BYTE_W-1:0] UNLOCK_DATA_2 = 8'h55;
   localparam logic [BYTE_W-1:0] UNLOCK_DATA_3 = 8'hA0;

   // Result steps of one job, in emission order.
   localparam int STEP_U1     = 0;
   localparam int STEP_U2     = 1;
   localparam int STEP_U3     = 2;
   localparam int STEP_LOAD   = 3;
   localparam int STEP_COMMIT = 4;
   localparam int STEP_READ   = 5;
   localparam int STEP_RESP   = 6;
   localparam int STEP_ACK    = 7;
   localparam int STEP_DONE   = 8;
   localparam int NUM_STEPS   = 9;

   typedef enum logic [1:0] {
      OP_START_PROGRAM = 2'd0,
      OP_START_VERIFY  = 2'd1,
      OP_DATA          = 2'd2,
      OP_TIMEOUT       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_PROGRAM = 2'd1,
      MODE_VERIFY  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      KIND_UNLOCK   = 3'd0,
      KIND_LOAD     = 3'd1,
      KIND_COMMIT   = 3'd2,
      KIND_READ     = 3'd3,
      KIND_RESPONSE = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      RESP_NONE         = 3'd0,
      RESP_OK           = 3'd1,
      RESP_ACK          = 3'd2,
      RESP_DONE         = 3'd3,
      RESP_INVALID_SIZE = 3'd4,
      RESP_TIMEOUT      = 3'd5,
      RESP_MISMATCH     = 3'd6
   } resp_type;

   // Work for the back: which steps to emit and the payload they need.
   typedef struct packed {
      logic [NUM_STEPS-1:0] steps;
      resp_type             resp;
      logic                 owned;
      logic [ADDR_W-1:0]    addr;
      logic [BYTE_W-1:0]    data;
   } job_type;

endpackage

FILE: design/pfpv_front.sv
// Front of the sequencer: accepts host items, tracks run mode and position, builds jobs.
// Depends on pfpv_pkg.
module pfpv_front
   import pfpv_pkg::*;
#(
   parameter int PAGE_BYTES  = 256,
   parameter int CHUNK_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        operation,
   input  logic [BYTE_W-1:0] host_byte,
   input  logic [BYTE_W-1:0] flash_byte,
   input  logic [SIZE_W-1:0] total_bytes,
   output logic              job_valid,
   output job_type           job
);

   localparam logic [POS_W-1:0] CHUNK_MASK = POS_W'(CHUNK_BYTES - 1);
   localparam logic [POS_W-1:0] PAGE_MASK  = POS_W'(PAGE_BYTES - 1);
   // Bytes of a chunk that fall in whole pages; the rest of a chunk is not written.
   localparam logic [POS_W-1:0] WRITE_SPAN =
      POS_W'((CHUNK_BYTES / PAGE_BYTES) * PAGE_BYTES);

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SIZE_W-1:0] total_ff, total_in;
   logic [POS_W-1:0]  end_ff, end_in;

   op_type            op;
   logic              size_bad;
   logic [POS_W-1:0]  pos_next;
   logic              chunk_end;
   logic              run_end;
   logic              write_ok;
   logic              in_range;

   assign op        = op_type'(operation);
   assign size_bad  = (total_bytes == '0) || ({12'd0, total_bytes} > FLASH_BYTES);
   assign pos_next  = pos_ff + POS_W'(1);
   assign chunk_end = (pos_next & CHUNK_MASK) == '0;
   assign run_end   = pos_next >= end_ff;
   assign write_ok  = (pos_ff & CHUNK_MASK) < WRITE_SPAN;
   assign in_range  = pos_ff < POS_W'(total_ff);

   // Classify the item, build its job and the next run state.
   always_comb begin
      job       = '0;
      job.resp  = RESP_NONE;
      job.addr  = pos_ff[ADDR_W-1:0];
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      total_in  = total_ff;
      end_in    = end_ff;
      unique case (op)
         OP_START_PROGRAM, OP_START_VERIFY: begin
            pos_in = '0;
            job.steps[STEP_RESP] = 1'b1;
            job.addr = '0;
            if (size_bad) begin
               mode_in   = MODE_IDLE;
               job.resp  = RESP_INVALID_SIZE;
               job.owned = 1'b0;
            end else begin
               mode_in   = (op == OP_START_PROGRAM) ? MODE_PROGRAM : MODE_VERIFY;
               job.resp  = RESP_OK;
               job.owned = 1'b1;
               total_in  = total_bytes;
               end_in    = (POS_W'(total_bytes) + CHUNK_MASK) & ~CHUNK_MASK;
            end
         end
         OP_TIMEOUT: begin
            if (mode_ff != MODE_IDLE) begin
               mode_in   = MODE_IDLE;
               pos_in    = '0;
               job.steps[STEP_RESP] = 1'b1;
               job.addr  = '0;
               job.resp  = RESP_TIMEOUT;
               job.owned = 1'b0;
            end
         end
         OP_DATA: begin
            unique case (mode_ff)
               MODE_PROGRAM: begin
                  if (write_ok) begin
                     if ((pos_ff & PAGE_MASK) == '0) begin
                        job.steps[STEP_U1] = 1'b1;
                        job.steps[STEP_U2] = 1'b1;
                        job.steps[STEP_U3] = 1'b1;
                     end
                     job.steps[STEP_LOAD] = 1'b1;
                     job.data = host_byte;
                     if ((pos_ff & PAGE_MASK) == PAGE_MASK) begin
                        job.steps[STEP_COMMIT] = 1'b1;
                     end
                  end
                  pos_in = pos_next;
                  job.steps[STEP_ACK] = chunk_end;
                  if (run_end) begin
                     job.steps[STEP_DONE] = 1'b1;
                     mode_in = MODE_IDLE;
                     pos_in  = '0;
                  end
               end
               MODE_VERIFY: begin
                  if (in_range && (flash_byte != host_byte)) begin
                     // First mismatch ends the run and reports its offset.
                     job.steps[STEP_READ] = 1'b1;
                     job.steps[STEP_RESP] = 1'b1;
                     job.resp  = RESP_MISMATCH;
                     job.owned = 1'b0;
                     mode_in   = MODE_IDLE;
                     pos_in    = '0;
                  end else begin
                     job.steps[STEP_READ] = in_range;
                     pos_in = pos_next;
                     job.steps[STEP_ACK] = chunk_end;
                     if (run_end) begin
                        job.steps[STEP_DONE] = 1'b1;
                        mode_in = MODE_IDLE;
                        pos_in  = '0;
                     end
                  end
               end
               default: begin
                  // A byte while idle is dropped.
               end
            endcase
         end
      endcase
   end

   assign job_valid = accept && (job.steps != '0);

   // Run state advances on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

   // Run size and chunk-rounded end, sampled at start.
   always_ff @(posedge clock) begin
      if (accept) begin
         total_ff <= total_in;
         end_ff   <= end_in;
      end
   end

endmodule

FILE: design/pfpv_queue.sv
// Short job queue between the front and the back of the sequencer.
// Depends on pfpv_pkg.
module pfpv_queue
   import pfpv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output job_type rd_data,
   output logic    empty
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/pfpv_back.sv
// Back of the sequencer: expands each job into bus-cycle and response results.
// Depends on pfpv_pkg; fed by pfpv_queue.
module pfpv_back
   import pfpv_pkg::*;
#(
   parameter int PAGE_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  job_type           q_data,
   input  logic              q_empty,
   output logic              q_rd,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [2:0]        rsp_kind,
   output logic [ADDR_W-1:0] rsp_bus_address,
   output logic [BYTE_W-1:0] rsp_bus_data,
   output logic [2:0]        rsp_response,
   output logic              rsp_bus_owned,
   output logic              rsp_last
);

   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

   logic [NUM_STEPS-1:0] mask_ff, mask_in;
   job_type              job_ff, job_in;
   logic                 out_valid_ff, out_valid_in;
   kind_type             kind_ff, kind_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [BYTE_W-1:0]    data_ff, data_in;
   resp_type             resp_ff, resp_in;
   logic                 owned_ff, owned_in;
   logic                 last_ff, last_in;

   logic                 busy;
   logic                 advance;
   logic [NUM_STEPS-1:0] rest;

   assign busy    = mask_ff != '0;
   assign advance = busy && (!out_valid_ff || rsp_pop);
   assign rest    = mask_ff & (mask_ff - NUM_STEPS'(1));
   assign q_rd    = !q_empty && (!busy || (advance && (rest == '0)));

   // Step mask and current job.
   always_comb begin
      mask_in = mask_ff;
      job_in  = job_ff;
      if (q_rd) begin
         mask_in = q_data.steps;
         job_in  = q_data;
      end else if (advance) begin
         mask_in = rest;
      end
   end

   // Result for the lowest pending step.
   always_comb begin
      kind_in  = KIND_RESPONSE;
      addr_in  = '0;
      data_in  = '0;
      resp_in  = RESP_NONE;
      owned_in = 1'b1;
      priority if (mask_ff[STEP_U1]) begin
         kind_in = KIND_UNLOCK;
         addr_in = UNLOCK_ADDR_1;
         data_in = UNLOCK_DATA_1;
      end else if (mask_ff[STEP_U2]) begin
         kind_in = KIND_UNLOCK;
         addr_in = UNLOCK_ADDR_2;
         data_in = UNLOCK_DATA_2;
      end else if (mask_ff[STEP_U3]) begin
         kind_in = KIND_UNLOCK;
         addr_in = UNLOCK_ADDR_3;
         data_in = UNLOCK_DATA_3;
      end else if (mask_ff[STEP_LOAD]) begin
         kind_in = KIND_LOAD;
         addr_in = job_ff.addr;
         data_in = job_ff.data;
      end else if (mask_ff[STEP_COMMIT]) begin
         kind_in = KIND_COMMIT;
         addr_in = job_ff.addr & ~PAGE_MASK;
      end else if (mask_ff[STEP_READ]) begin
         kind_in = KIND_READ;
         addr_in = job_ff.addr;
      end else if (mask_ff[STEP_RESP]) begin
         addr_in  = job_ff.addr;
         resp_in  = job_ff.resp;
         owned_in = job_ff.owned;
      end else if (mask_ff[STEP_ACK]) begin
         resp_in = RESP_ACK;
      end else begin
         // Done: the bus is released with it.
         resp_in  = RESP_DONE;
         owned_in = 1'b0;
      end
      last_in = rest == '0;
   end

   assign out_valid_in = advance ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Job and output payload.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (advance) begin
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         resp_ff  <= resp_in;
         owned_ff <= owned_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_bus_address = addr_ff;
   assign rsp_bus_data    = data_ff;
   assign rsp_response    = resp_ff;
   assign rsp_bus_owned   = owned_ff;
   assign rsp_last        = last_ff;

endmodule

FILE: design/parallel_flash_program_verify.sv
// Top level of the parallel flash program/verify sequencer and its size register.
// Depends on pfpv_pkg, pfpv_front, pfpv_queue and pfpv_back.
//
//   Channel  Ports                          Handshake
//   req      operation, host/flash byte     push/full, taken at push & !full
//   rsp      kind, address, data, response  empty/pop, taken at pop & !empty
//   csr      psel/penable/pwrite/paddr      APB write on access cycle, pready tied high
//
// The front takes one item per cycle while the four-entry job queue has room.
// The back emits one result per cycle while the result register drains; it emits
// an item's results (one to seven) in order and loads the next job with the last one.
// A full result register stalls the back, a full job queue raises full.
// Reset is synchronous and clears mode, position, queue and the size register.
// PAGE_BYTES and CHUNK_BYTES must be powers of two; the block itself does not check this.
module parallel_flash_program_verify
   import pfpv_pkg::*;
#(
   parameter int PAGE_BYTES  = 256,
   parameter int CHUNK_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_operation,
   input  logic [BYTE_W-1:0] req_host_byte,
   input  logic [BYTE_W-1:0] req_flash_byte,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [2:0]        rsp_kind,
   output logic [ADDR_W-1:0] rsp_bus_address,
   output logic [BYTE_W-1:0] rsp_bus_data,
   output logic [2:0]        rsp_response,
   output logic              rsp_bus_owned,
   output logic              rsp_last,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [SIZE_W-1:0] total_bytes_ff, total_bytes_in;
   logic              csr_write;
   logic              accept;
   logic              job_valid;
   job_type           job;
   job_type           q_data;
   logic              q_empty;
   logic              q_rd;

   // Size register; the only register sits at byte address zero, decoded from paddr bit 2 alone.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign total_bytes_in = (csr_write && !csr_paddr[2]) ? csr_pwdata[SIZE_W-1:0]
                                                        : total_bytes_ff;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {12'd0, total_bytes_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bytes_ff <= '0;
      end else begin
         total_bytes_ff <= total_bytes_in;
      end
   end

   assign accept = req_push && !req_full;

   pfpv_front #(
      .PAGE_BYTES  (PAGE_BYTES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .host_byte   (req_host_byte),
      .flash_byte  (req_flash_byte),
      .total_bytes (total_bytes_ff),
      .job_valid   (job_valid),
      .job         (job)
   );

   pfpv_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_valid),
      .wr_data (job),
      .full    (req_full),
      .rd_en   (q_rd),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   pfpv_back #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (q_data),
      .q_empty         (q_empty),
      .q_rd            (q_rd),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_kind        (rsp_kind),
      .rsp_bus_address (rsp_bus_address),
      .rsp_bus_data    (rsp_bus_data),
      .rsp_response    (rsp_response),
      .rsp_bus_owned   (rsp_bus_owned),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: sim/tb_parallel_flash_program_verify.sv
// Self-checking testbench for the parallel flash program/verify sequencer.
// Drives host items and size register writes, predicts every bus cycle and response.
// Depends on pfpv_pkg and parallel_flash_program_verify.
module tb_parallel_flash_program_verify
   import pfpv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_BYTES  = 256;
   localparam int CHUNK_BYTES = 4096;
   localparam logic [2:0] CSR_TOTAL_BYTES = 3'd0;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 36;

   // Predicts the bus cycles and host responses of the sequencer and holds the
   // ones not yet seen on the result port.
   class flash_cycle_predictor;
      typedef struct {
         kind_type          kind;
         logic [ADDR_W-1:0] addr;
         logic [BYTE_W-1:0] data;
         resp_type          resp;
         logic              owned;
         logic              last;
      } bus_result_type;

      bus_result_type pending_cycles[$];
      bus_result_type batch[$];
      mode_type    mode;
      int unsigned position;
      int unsigned size_reg;
      int unsigned run_size;
      int          failures;

      function new();
         mode = MODE_IDLE;
         position = 0;
         size_reg = 0;
         run_size = 0;
         failures = 0;
      endfunction

      function void set_size(logic [SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      function void stop_run();
         mode = MODE_IDLE;
         position = 0;
      endfunction

      function void emit(kind_type k, int unsigned a, int unsigned d, resp_type r,
                         logic o);
         bus_result_type c;
         c.kind = k;
         c.addr = a[ADDR_W-1:0];
         c.data = d[BYTE_W-1:0];
         c.resp = r;
         c.owned = o;
         c.last = 1'b0;
         batch.push_back(c);
      endfunction

      // One host data byte in program or verify mode.
      function void data_byte(logic [BYTE_W-1:0] hb, logic [BYTE_W-1:0] fb);
         int unsigned q;
         int unsigned idx;
         int unsigned base;
         int unsigned padded;
         if (mode == MODE_IDLE) return;
         if (mode == MODE_PROGRAM) begin
            q = position % CHUNK_BYTES;
            idx = q % PAGE_BYTES;
            // Bytes past the last whole page of a chunk are never written.
            if (q / PAGE_BYTES < CHUNK_BYTES / PAGE_BYTES) begin
               base = position - q + (q / PAGE_BYTES) * PAGE_BYTES;
               if (idx == 0) begin
                  emit(KIND_UNLOCK, UNLOCK_ADDR_1, UNLOCK_DATA_1, RESP_NONE, 1'b1);
                  emit(KIND_UNLOCK, UNLOCK_ADDR_2, UNLOCK_DATA_2, RESP_NONE, 1'b1);
                  emit(KIND_UNLOCK, UNLOCK_ADDR_3, UNLOCK_DATA_3, RESP_NONE, 1'b1);
               end
               emit(KIND_LOAD, base + idx, hb, RESP_NONE, 1'b1);
               if (idx == PAGE_BYTES - 1) emit(KIND_COMMIT, base, 0, RESP_NONE, 1'b1);
            end
         end else if (position < run_size) begin
            // Only unpadded bytes are read back; the first mismatch ends the run.
            emit(KIND_READ, position, 0, RESP_NONE, 1'b1);
            if (fb != hb) begin
               emit(KIND_RESPONSE, position, 0, RESP_MISMATCH, 1'b0);
               stop_run();
               return;
            end
         end
         position++;
         if (position % CHUNK_BYTES == 0) emit(KIND_RESPONSE, 0, 0, RESP_ACK, 1'b1);
         padded = ((run_size + CHUNK_BYTES - 1) / CHUNK_BYTES) * CHUNK_BYTES;
         if (position >= padded) begin
            stop_run();
            emit(KIND_RESPONSE, 0, 0, RESP_DONE, 1'b0);
         end
      endfunction

      // Notes an accepted host item; returns the number of results it causes.
      function int take_item(op_type op, logic [BYTE_W-1:0] hb, logic [BYTE_W-1:0] fb);
         batch.delete();
         case (op)
            OP_START_PROGRAM, OP_START_VERIFY: begin
               // A start drops any run in progress without a response.
               stop_run();
               if (size_reg == 0 || size_reg > FLASH_BYTES) begin
                  emit(KIND_RESPONSE, 0, 0, RESP_INVALID_SIZE, 1'b0);
               end else begin
                  run_size = size_reg;
                  if (op == OP_START_PROGRAM) mode = MODE_PROGRAM;
                  else mode = MODE_VERIFY;
                  emit(KIND_RESPONSE, 0, 0, RESP_OK, 1'b1);
               end
            end
            OP_TIMEOUT: begin
               if (mode != MODE_IDLE) begin
                  stop_run();
                  emit(KIND_RESPONSE, 0, 0, RESP_TIMEOUT, 1'b0);
               end
            end
            default: data_byte(hb, fb);
         endcase
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) pending_cycles.push_back(batch[i]);
         return batch.size();
      endfunction

      function void compare_field(string name, logic [31:0] expected_value,
                                  logic [31:0] actual_value);
         if (actual_value !== expected_value) begin
            $error("%s: expected %0d, actual %0d", name, expected_value, actual_value);
            failures++;
         end
      endfunction

      // Checks one result transaction against the oldest prediction.
      function void check_cycle(logic [2:0] kind, logic [ADDR_W-1:0] addr,
                                logic [BYTE_W-1:0] data, logic [2:0] resp,
                                logic owned, logic last);
         bus_result_type c;
         if (pending_cycles.size() == 0) begin
            $error("result with nothing predicted: kind %0d address %0d response %0d",
                   kind, addr, resp);
            failures++;
            return;
         end
         c = pending_cycles.pop_front();
         compare_field("kind", c.kind, kind);
         compare_field("bus_address", c.addr, addr);
         compare_field("bus_data", c.data, data);
         compare_field("response", c.resp, resp);
         compare_field("bus_owned", c.owned, owned);
         compare_field("last", c.last, last);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [1:0]        req_operation = '0;
   logic [BYTE_W-1:0] req_host_byte = '0;
   logic [BYTE_W-1:0] req_flash_byte = '0;
   logic              rsp_pop = 1'b0;
   logic              rsp_empty;
   logic [2:0]        rsp_kind;
   logic [ADDR_W-1:0] rsp_bus_address;
   logic [BYTE_W-1:0] rsp_bus_data;
   logic [2:0]        rsp_response;
   logic              rsp_bus_owned;
   logic              rsp_last;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   flash_cycle_predictor predictor = new();
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int counted_items = 0;
   int cycle_count = 0;

   parallel_flash_program_verify #(
      .PAGE_BYTES (PAGE_BYTES),
      .CHUNK_BYTES(CHUNK_BYTES)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_operation  (req_operation),
      .req_host_byte  (req_host_byte),
      .req_flash_byte (req_flash_byte),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_kind       (rsp_kind),
      .rsp_bus_address(rsp_bus_address),
      .rsp_bus_data   (rsp_bus_data),
      .rsp_response   (rsp_response),
      .rsp_bus_owned  (rsp_bus_owned),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Overall watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // The result side stalls at random, decided at each falling edge.
   always @(negedge clock) begin
      rsp_pop = ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Every result transaction is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         predictor.check_cycle(rsp_kind, rsp_bus_address, rsp_bus_data, rsp_response,
                               rsp_bus_owned, rsp_last);
      end
   end

   // Enters and leaves at a falling edge; push stays high for a following item.
   task automatic send_item(op_type op, logic [BYTE_W-1:0] hb, logic [BYTE_W-1:0] fb);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_operation = op;
      req_host_byte = hb;
      req_flash_byte = fb;
      do @(posedge clock); while (req_full);
      void'(predictor.take_item(op, hb, fb));
      counted_items++;
      @(negedge clock);
   endtask

   // Lets every predicted result drain, then the block settle.
   task automatic wait_idle();
      req_push = 1'b0;
      while (predictor.pending_cycles.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes total_bytes over the register port and reads it back.
   task automatic write_total_bytes(logic [SIZE_W-1:0] value);
      wait_idle();
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_TOTAL_BYTES;
      csr_pwdata = {{(32 - SIZE_W){1'b0}}, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      predictor.set_size(value);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[SIZE_W-1:0] !== value) begin
         $error("total_bytes readback: expected %0d, actual %0d", value,
                csr_prdata[SIZE_W-1:0]);
         predictor.failures++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   // A start followed by a burst of bytes with some noise, often cut off by a timeout.
   task automatic run_sequence();
      int unsigned n;
      int unsigned r;
      logic [BYTE_W-1:0] hb;
      send_item(op_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      n = $urandom_range(1, 24);
      repeat (n) begin
         hb = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 19) == 0) begin
            send_item(op_type'($urandom_range(0, 3)), hb, 8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 19) == 0) begin
            send_item(OP_DATA, hb, 8'($urandom_range(0, 255)));
         end else begin
            send_item(OP_DATA, hb, hb);
         end
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
         send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (r == 4) begin
         send_item(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   // Picks a size, mostly small and valid, now and then an extreme or invalid one.
   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 12) return SIZE_W'($urandom_range(524289, 1048575));
      if (r < 16) return SIZE_W'(FLASH_BYTES);
      if (r < 20) return SIZE_W'(1);
      return SIZE_W'($urandom_range(2, 600));
   endfunction

   initial begin
      int goal;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: size register at reset, idle items, size limits,
      // timeout, mismatch and starts during a run.
      send_item(OP_START_PROGRAM, 8'h00, 8'h00);
      send_item(OP_DATA, 8'hFF, 8'h00);
      send_item(OP_TIMEOUT, 8'h00, 8'hFF);
      write_total_bytes(20'hFFFFF);
      send_item(OP_START_VERIFY, 8'h00, 8'h00);
      write_total_bytes(SIZE_W'(FLASH_BYTES + 1));
      send_item(OP_START_PROGRAM, 8'h00, 8'h00);
      write_total_bytes(SIZE_W'(FLASH_BYTES));
      send_item(OP_START_PROGRAM, 8'h00, 8'h00);
      send_item(OP_DATA, 8'h00, 8'h00);
      send_item(OP_DATA, 8'hFF, 8'hFF);
      send_item(OP_TIMEOUT, 8'h00, 8'h00);
      send_item(OP_START_VERIFY, 8'h00, 8'h00);
      send_item(OP_DATA, 8'hFF, 8'hFF);
      send_item(OP_DATA, 8'h00, 8'h00);
      send_item(OP_DATA, 8'h00, 8'hFF);
      send_item(OP_DATA, 8'hA5, 8'hA5);
      write_total_bytes(SIZE_W'(1));
      send_item(OP_START_VERIFY, 8'h00, 8'h00);
      send_item(OP_DATA, 8'h3C, 8'h3C);
      send_item(OP_DATA, 8'h12, 8'h34);
      send_item(OP_START_PROGRAM, 8'h00, 8'h00);
      send_item(OP_DATA, 8'h5A, 8'h00);
      send_item(OP_START_VERIFY, 8'h00, 8'h00);
      send_item(OP_DATA, 8'hFF, 8'h00);
      send_item(OP_START_PROGRAM, 8'h00, 8'h00);
      send_item(OP_TIMEOUT, 8'h00, 8'h00);
      write_total_bytes('0);
      send_item(OP_START_VERIFY, 8'h00, 8'h00);

      // Random part, one phase per idling pattern, each pattern twice.
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin sender_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         write_total_bytes(pick_size());
         goal = counted_items + PHASE_ITEMS;
         while (counted_items < goal) run_sequence();
      end

      wait_idle();
      if (predictor.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
